### sv/hbdfb_pkg.sv
// shared types, request codes and word format for the half-bridge frame builder
package hbdfb_pkg;

  // chip and channel geometry
  localparam int unsigned ChipCountDef = 3;
  localparam int unsigned BitsPerChip  = 12;
  localparam int unsigned HalfBits     = 6;

  typedef logic [BitsPerChip-1:0] chip_bits_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_SET     = 2'd0,
    REQ_DISABLE = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_WRITE   = 2'd3
  } req_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_e;

  // control bundle broadcast from the sequencer to every cell
  typedef struct packed {
    logic       rotate;
    logic       set_ch;
    logic       dis_ch;
    logic       clr_all;
    logic       high_side;
    logic [5:0] channel;
  } cell_ctrl_t;

  // command word for one chip and one half, bytes swapped
  function automatic logic [15:0] build_word(input chip_bits_t en, input chip_bits_t hs,
                                             input logic half);
    logic [HalfBits-1:0] en_h;
    logic [HalfBits-1:0] hs_h;
    logic [15:0]         w;
    en_h = half ? en[BitsPerChip-1:HalfBits] : en[HalfBits-1:0];
    hs_h = half ? hs[BitsPerChip-1:HalfBits] : hs[HalfBits-1:0];
    w    = {1'b1, half, 1'b0, en_h, hs_h, 1'b0};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

### sv/half_bridge_daisy_frame_builder.sv
// top level: daisy-chain half-bridge command frame builder
//
// Input channel (in_valid_i/in_ready_o) takes one request item: set a
// channel, disable a channel, clear all, or write. Set, disable and clear
// give no result item. A write gives 2*CHIP_COUNT result
// items on the output channel (out_valid_o/out_ready_i): the half-0 frame,
// farthest chip first, then the half-1 frame; frame_end_o marks chip 0 and
// last_o the final item. The state lives in a ring of per-chip cells; a
// write rotates the ring once per emitted item, so after 2*CHIP_COUNT
// rotations it is back in place. Each item is formed into the output
// register, and items leave at one item per cycle when the receiver is
// ready; requests are not taken until the final item of a write has
// been formed. A stalled receiver freezes the ring rotation.
// Reset clears all enable and high-side bits and the output valid flag.
module half_bridge_daisy_frame_builder #(
  parameter int unsigned CHIP_COUNT = hbdfb_pkg::ChipCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  channel_i,
  input  logic        high_side_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] spi_word_o,
  output logic [1:0]  chip_index_o,
  output logic        half_select_o,
  output logic        frame_end_o,
  output logic        last_o
);
  import hbdfb_pkg::*;

  cell_ctrl_t ctrl;
  chip_bits_t en_w [CHIP_COUNT];
  chip_bits_t hs_w [CHIP_COUNT];

  // ring of chip cells, each fed by its lower neighbor, cell 0 by the top
  for (genvar i = 0; i < CHIP_COUNT; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? CHIP_COUNT - 1 : i - 1;
    hbdfb_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_en_i (en_w[Prev]),
      .prev_hs_i (hs_w[Prev]),
      .en_o      (en_w[i]),
      .hs_o      (hs_w[i])
    );
  end

  // sequencer and output register
  hbdfb_seq #(
    .CHIP_COUNT (CHIP_COUNT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .channel_i     (channel_i),
    .high_side_i   (high_side_i),
    .tail_en_i     (en_w[CHIP_COUNT-1]),
    .tail_hs_i     (hs_w[CHIP_COUNT-1]),
    .ctrl_o        (ctrl),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .spi_word_o    (spi_word_o),
    .chip_index_o  (chip_index_o),
    .half_select_o (half_select_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o)
  );

endmodule

### sv/hbdfb_cell.sv
// one chip's enable and high-side bits, as a link of the rotating chain
module hbdfb_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hbdfb_pkg::cell_ctrl_t    ctrl_i,
  input  hbdfb_pkg::chip_bits_t    prev_en_i,
  input  hbdfb_pkg::chip_bits_t    prev_hs_i,
  output hbdfb_pkg::chip_bits_t    en_o,
  output hbdfb_pkg::chip_bits_t    hs_o
);
  import hbdfb_pkg::*;

  localparam logic [7:0] ChLo = 8'(CELL_IDX * BitsPerChip);
  localparam logic [7:0] ChHi = 8'((CELL_IDX + 1) * BitsPerChip);

  chip_bits_t en_q, en_d;
  chip_bits_t hs_q, hs_d;
  logic [7:0] ch_ext;
  logic       hit;
  logic [3:0] bit_idx;
  chip_bits_t mask;

  // channel decode against this cell's range
  assign ch_ext  = {2'b00, ctrl_i.channel};
  assign hit     = (ch_ext >= ChLo) && (ch_ext < ChHi);
  assign bit_idx = 4'(ch_ext - ChLo);
  assign mask    = chip_bits_t'(1) << bit_idx;

  // next state
  always_comb begin
    en_d = en_q;
    hs_d = hs_q;
    if (ctrl_i.clr_all) begin
      en_d = '0;
      hs_d = '0;
    end else if (ctrl_i.rotate) begin
      en_d = prev_en_i;
      hs_d = prev_hs_i;
    end else if (ctrl_i.set_ch && hit) begin
      en_d = en_q | mask;
      hs_d = ctrl_i.high_side ? (hs_q | mask) : (hs_q & ~mask);
    end else if (ctrl_i.dis_ch && hit) begin
      en_d = en_q & ~mask;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      hs_q <= '0;
    end else begin
      en_q <= en_d;
      hs_q <= hs_d;
    end
  end

  assign en_o = en_q;
  assign hs_o = hs_q;

endmodule

### sv/hbdfb_seq.sv
// request decode, write sequencing and output register
module hbdfb_seq #(
  parameter int unsigned CHIP_COUNT = hbdfb_pkg::ChipCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [5:0]            channel_i,
  input  logic                  high_side_i,
  input  hbdfb_pkg::chip_bits_t tail_en_i,
  input  hbdfb_pkg::chip_bits_t tail_hs_i,
  output hbdfb_pkg::cell_ctrl_t ctrl_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           spi_word_o,
  output logic [1:0]            chip_index_o,
  output logic                  half_select_o,
  output logic                  frame_end_o,
  output logic                  last_o
);
  import hbdfb_pkg::*;

  localparam int unsigned CW = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
  localparam logic [CW-1:0] ChipTop = CW'(CHIP_COUNT - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] chip_q, chip_d;
  logic          half_q, half_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   word_q;
  logic [1:0]    idx_q;
  logic          hsel_q, fend_q, last_q;
  logic          accept;
  logic          emit;
  logic          run_done;
  req_e          req;

  assign req      = req_e'(req_type_i);
  assign accept   = in_valid_i && in_ready_o;
  assign emit     = (state_q == ST_SEND) && (!out_valid_q || out_ready_i);
  assign run_done = (chip_q == '0) && half_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req == REQ_WRITE)) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (emit && run_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    ctrl_o.rotate    = emit;
    ctrl_o.set_ch    = accept && (req == REQ_SET);
    ctrl_o.dis_ch    = accept && (req == REQ_DISABLE);
    ctrl_o.clr_all   = accept && (req == REQ_CLEAR);
    ctrl_o.high_side = high_side_i;
    ctrl_o.channel   = channel_i;
    chip_d           = chip_q;
    half_d           = half_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    if (accept && (req == REQ_WRITE)) begin
      chip_d = ChipTop;
      half_d = 1'b0;
    end else if (emit) begin
      out_valid_d = 1'b1;
      if (chip_q == '0) begin
        chip_d = ChipTop;
        half_d = 1'b1;
      end else begin
        chip_d = chip_q - CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chip_q      <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chip_q      <= chip_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q <= build_word(tail_en_i, tail_hs_i, half_q);
      idx_q  <= 2'(chip_q);
      hsel_q <= half_q;
      fend_q <= (chip_q == '0);
      last_q <= run_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign spi_word_o    = word_q;
  assign chip_index_o  = idx_q;
  assign half_select_o = hsel_q;
  assign frame_end_o   = fend_q;
  assign last_o        = last_q;

`ifndef SYNTH
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> frame_end_o && half_select_o)
    else $error("last item not at end of second frame");
  a_run_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && run_done |=> state_q == ST_IDLE)
    else $error("write run did not stop after final item");
  a_chip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> chip_q <= ChipTop)
    else $error("chip counter out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !ctrl_o.set_ch && !ctrl_o.dis_ch && !ctrl_o.clr_all)
    else $error("request taken while shifting out");
`endif

endmodule
